@@ rtl/mpel_pkg.sv @@
// ----------------------------------------------------------------------------
// Motor power estimate and limit: shared package
// Widths, fixed-point coefficients, pipeline geometry and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package mpel_pkg;

  // Field widths
  localparam int NUM_MOTORS = 4;
  localparam int CUR_W      = 16;
  localparam int SPD_W      = 16;
  localparam int CAP_W      = 15;
  localparam int LIM_W      = 10;
  localparam int THR_W      = 15;
  localparam int CFG_W      = 15;
  localparam int CFG_IDX_W  = 1;
  localparam int SCALE_W    = 17;
  localparam int MW_W       = 24;
  localparam int FRAC_W     = 16;

  // Per-motor model in Q.40
  localparam int PROD_W = 32;             // signed i*w
  localparam int SQ_W   = 31;             // i*i and w*w, at most 2^30
  localparam int TC_W   = 22;
  localparam int K2_W   = 20;
  localparam int K1_W   = 18;
  localparam logic [TC_W-1:0] TC_Q40 = 22'd2195604;
  localparam logic [K2_W-1:0] K2_Q40 = 20'd731505;
  localparam logic [K1_W-1:0] K1_Q40 = 18'd135240;
  localparam int SUM_W  = 55;
  localparam logic signed [SUM_W-1:0] CONST_Q40 = SUM_W'(64'd267452 << 24);

  // |P| * 20 / (17 * 2^24), rounded: the 2^24 is a shift, the 17 a reciprocal
  localparam int X_W      = SUM_W + 5;
  localparam int MUL20    = 20;
  localparam int DEN_SH   = 24;
  localparam logic [X_W-1:0] Y_RND = X_W'(64'd17 << 23);
  localparam int Y_W      = 32;
  localparam int RCP_W    = 28;
  localparam logic [RCP_W-1:0] RECIP17 = 28'd252645135;  // floor(2^32 / 17)
  localparam int MOT_DEN  = 17;
  localparam int QM_W     = 28;

  localparam int EST_W = QM_W + $clog2(NUM_MOTORS);
  localparam int REM_W = EST_W + 1;
  localparam int CMP_W = EST_W + 2;

  // Allowance in signed Q12.16 watts
  localparam int ALLOW_W = 28;
  localparam logic [ALLOW_W-1:0] MARGIN_Q16 = ALLOW_W'(131072);
  localparam int MUL_W     = CAP_W + 10;
  localparam logic [9:0] BOOST_MUL = 10'd819;     // 4096 = 5*819 + 1
  localparam int BOOST_RND = 2;
  localparam int P5_W      = CAP_W + 1 + 16;
  localparam logic [15:0] DIV5_RCP = 16'd52429;   // 5*52429 = 2^18 + 1
  localparam int DIV5_SH   = 18;
  localparam int D5_W      = P5_W - DIV5_SH;

  // Milliwatt conversion
  localparam int MW_MUL = 1000;
  localparam int MW_RND = 32768;
  localparam int MW_SH  = 16;
  localparam int MWF_W  = EST_W + 11;
  localparam int MWH_W  = MWF_W - MW_SH;
  localparam logic [MW_W-1:0] MW_MAX = '1;

  localparam logic [SCALE_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [SCALE_W-1:0] BIAS_Q16 = 17'd66;

  localparam logic [LIM_W-1:0] LIMIT_RST = 10'd100;
  localparam logic [THR_W-1:0] THR_RST   = 15'd5000;

  // Pipeline geometry
  localparam int LANE_STG  = 6;
  localparam int MERGE_STG = 2;
  localparam int DIV_STG   = SCALE_W;
  localparam int DIV_FIRST = LANE_STG + MERGE_STG + 1;
  localparam int NST       = LANE_STG + MERGE_STG + DIV_STG + 1;
  localparam int DIV_LAST  = NST - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POWER_LIMIT   = 1'b0,
    REG_CAP_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef logic [NST:1] stg_vec_t;

  // Result information that travels alongside the divider
  typedef struct packed {
    logic [MW_W-1:0] mw;
    logic            gt;     // allowance above estimate
    logic            zero;   // allowance not positive or estimate zero
  } side_t;

endpackage

`default_nettype wire

@@ rtl/mpel_lane.sv @@
// ----------------------------------------------------------------------------
// Motor power lane
// Six-stage pipeline forming |tc*i*w + k2*w^2 + k1*i^2 + c| / 0.85 for one
// motor, in Q12.16 watts.
// ----------------------------------------------------------------------------
`default_nettype none

module mpel_lane (
  input  wire logic                               clk,
  input  wire logic [mpel_pkg::LANE_STG:1]        en,
  input  wire logic signed [mpel_pkg::CUR_W-1:0]  cur_i,
  input  wire logic signed [mpel_pkg::SPD_W-1:0]  spd_i,
  output logic [mpel_pkg::QM_W-1:0]               q_o
);

  logic signed [mpel_pkg::PROD_W-1:0] p_is_nxt, p_ii_full, p_ss_full;
  logic signed [mpel_pkg::PROD_W-1:0] p_is_r;
  logic [mpel_pkg::SQ_W-1:0]          p_ii_r, p_ss_r;

  logic signed [mpel_pkg::SUM_W-1:0]          t_is_r;
  logic [mpel_pkg::SQ_W+mpel_pkg::K2_W-1:0]   t_ss_r;
  logic [mpel_pkg::SQ_W+mpel_pkg::K1_W-1:0]   t_ii_r;

  logic signed [mpel_pkg::SUM_W-1:0] s_nxt, s_r;
  logic [mpel_pkg::SUM_W-1:0]        a_abs;
  logic [mpel_pkg::X_W-1:0]          x_val;
  logic [mpel_pkg::Y_W-1:0]          y_r, y5_r;

  logic [mpel_pkg::Y_W+mpel_pkg::RCP_W-1:0] prod_r;
  logic [mpel_pkg::QM_W-1:0]                qe;
  logic [mpel_pkg::Y_W:0]                   rem;
  logic [mpel_pkg::QM_W-1:0]                q_nxt, q_r;

  assign p_is_nxt  = mpel_pkg::PROD_W'(cur_i) * mpel_pkg::PROD_W'(spd_i);
  assign p_ii_full = mpel_pkg::PROD_W'(cur_i) * mpel_pkg::PROD_W'(cur_i);
  assign p_ss_full = mpel_pkg::PROD_W'(spd_i) * mpel_pkg::PROD_W'(spd_i);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_is_r <= p_is_nxt;
      p_ii_r <= p_ii_full[mpel_pkg::SQ_W-1:0];
      p_ss_r <= p_ss_full[mpel_pkg::SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      t_is_r <= mpel_pkg::SUM_W'($signed({1'b0, mpel_pkg::TC_Q40}))
              * mpel_pkg::SUM_W'(p_is_r);
      t_ss_r <= (mpel_pkg::SQ_W+mpel_pkg::K2_W)'(p_ss_r)
              * (mpel_pkg::SQ_W+mpel_pkg::K2_W)'(mpel_pkg::K2_Q40);
      t_ii_r <= (mpel_pkg::SQ_W+mpel_pkg::K1_W)'(p_ii_r)
              * (mpel_pkg::SQ_W+mpel_pkg::K1_W)'(mpel_pkg::K1_Q40);
    end
  end

  assign s_nxt = t_is_r + $signed(mpel_pkg::SUM_W'(t_ss_r))
               + $signed(mpel_pkg::SUM_W'(t_ii_r)) + mpel_pkg::CONST_Q40;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s_r <= s_nxt;
    end
  end

  // The whole model stays below 1.5 * 2^51, so twenty times it, rounded and divided by 2^24, fits 32 bits.
  assign a_abs = s_r[mpel_pkg::SUM_W-1] ? -s_r : s_r;
  assign x_val = mpel_pkg::X_W'(a_abs) * mpel_pkg::X_W'(mpel_pkg::MUL20) + mpel_pkg::Y_RND;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      y_r <= x_val[mpel_pkg::DEN_SH +: mpel_pkg::Y_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      prod_r <= (mpel_pkg::Y_W+mpel_pkg::RCP_W)'(y_r)
              * (mpel_pkg::Y_W+mpel_pkg::RCP_W)'(mpel_pkg::RECIP17);
      y5_r   <= y_r;
    end
  end

  // The truncated reciprocal undershoots by at most one; one correction step.
  assign qe    = prod_r[mpel_pkg::Y_W +: mpel_pkg::QM_W];
  assign rem   = {1'b0, y5_r}
               - (mpel_pkg::Y_W+1)'(qe) * (mpel_pkg::Y_W+1)'(mpel_pkg::MOT_DEN);
  assign q_nxt = (rem >= (mpel_pkg::Y_W+1)'(mpel_pkg::MOT_DEN))
               ? qe + mpel_pkg::QM_W'(1) : qe;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

`default_nettype wire

@@ rtl/mpel_allow.sv @@
// ----------------------------------------------------------------------------
// Power allowance
// Forms the allowed power in signed Q12.16 watts from the configured limit and
// the capacitor voltage, then keeps it in step with the motor lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module mpel_allow (
  input  wire logic                               clk,
  input  wire logic [mpel_pkg::LANE_STG:1]        en,
  input  wire logic [mpel_pkg::CAP_W-1:0]         cap_i,
  input  wire logic [mpel_pkg::LIM_W-1:0]         limit_i,
  input  wire logic [mpel_pkg::THR_W-1:0]         thr_i,
  output logic signed [mpel_pkg::ALLOW_W-1:0]     allow_o
);

  logic [mpel_pkg::CAP_W:0]     t5;
  logic [mpel_pkg::P5_W-1:0]    p5;
  logic                         low_r;
  logic [mpel_pkg::MUL_W-1:0]   mul_r;
  logic [mpel_pkg::D5_W-1:0]    d5_r;
  logic [mpel_pkg::ALLOW_W-1:0] base;
  logic [mpel_pkg::ALLOW_W-1:0] allow_nxt;
  logic signed [mpel_pkg::ALLOW_W-1:0] allow_r [2:mpel_pkg::LANE_STG];

  // round(cap * 4096 / 5) = 819 * cap + floor((cap + 2) / 5)
  assign t5 = (mpel_pkg::CAP_W+1)'(cap_i) + (mpel_pkg::CAP_W+1)'(mpel_pkg::BOOST_RND);
  assign p5 = mpel_pkg::P5_W'(t5) * mpel_pkg::P5_W'(mpel_pkg::DIV5_RCP);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      low_r <= (cap_i <= thr_i);
      mul_r <= mpel_pkg::MUL_W'(cap_i) * mpel_pkg::MUL_W'(mpel_pkg::BOOST_MUL);
      d5_r  <= p5[mpel_pkg::DIV5_SH +: mpel_pkg::D5_W];
    end
  end

  assign base      = mpel_pkg::ALLOW_W'(limit_i) << mpel_pkg::FRAC_W;
  assign allow_nxt = low_r ? base - mpel_pkg::MARGIN_Q16
                           : base + mpel_pkg::ALLOW_W'(mul_r) + mpel_pkg::ALLOW_W'(d5_r);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      allow_r[2] <= $signed(allow_nxt);
    end
  end

  for (genvar k = 3; k <= mpel_pkg::LANE_STG; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en[k]) begin
        allow_r[k] <= allow_r[k-1];
      end
    end
  end

  assign allow_o = allow_r[mpel_pkg::LANE_STG];

endmodule

`default_nettype wire

@@ rtl/mpel_merge.sv @@
// ----------------------------------------------------------------------------
// Lane merge
// Sums the motor lanes into the estimate, converts it to milliwatts and
// classifies the allowance against it ahead of the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module mpel_merge (
  input  wire logic                                                 clk,
  input  wire logic [mpel_pkg::MERGE_STG:1]                         en,
  input  wire logic [mpel_pkg::NUM_MOTORS-1:0][mpel_pkg::QM_W-1:0]  q_i,
  input  wire logic signed [mpel_pkg::ALLOW_W-1:0]                  allow_i,
  output logic [mpel_pkg::EST_W-1:0]                                est_o,
  output logic [mpel_pkg::EST_W-1:0]                                num_o,
  output mpel_pkg::side_t                                           side_o
);

  logic [mpel_pkg::EST_W-1:0]          sum;
  logic [mpel_pkg::EST_W-1:0]          est_r, est2_r, num_r;
  logic signed [mpel_pkg::ALLOW_W-1:0] allow_r;
  logic [mpel_pkg::MWF_W-1:0]          mwf;
  logic [mpel_pkg::MWH_W-1:0]          mw_hi;
  mpel_pkg::side_t                     side_nxt, side_r;

  always_comb begin
    sum = '0;
    for (int k = 0; k < mpel_pkg::NUM_MOTORS; k++) begin
      sum = sum + mpel_pkg::EST_W'(q_i[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      est_r   <= sum;
      allow_r <= allow_i;
    end
  end

  assign mwf   = mpel_pkg::MWF_W'(est_r) * mpel_pkg::MWF_W'(mpel_pkg::MW_MUL)
               + mpel_pkg::MWF_W'(mpel_pkg::MW_RND);
  assign mw_hi = mwf[mpel_pkg::MWF_W-1:mpel_pkg::MW_SH];

  always_comb begin
    side_nxt.mw   = (mw_hi > mpel_pkg::MWH_W'(mpel_pkg::MW_MAX))
                  ? mpel_pkg::MW_MAX : mpel_pkg::MW_W'(mw_hi);
    side_nxt.gt   = $signed(mpel_pkg::CMP_W'(allow_r)) > $signed(mpel_pkg::CMP_W'(est_r));
    side_nxt.zero = (allow_r <= 0) || (est_r == '0);
  end

  // Only a positive allowance at or below the estimate reaches the quotient,
  // so its magnitude bits are enough for the dividend.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      est2_r <= est_r;
      num_r  <= mpel_pkg::EST_W'(allow_r[mpel_pkg::ALLOW_W-2:0]);
      side_r <= side_nxt;
    end
  end

  assign est_o  = est2_r;
  assign num_o  = num_r;
  assign side_o = side_r;

endmodule

`default_nettype wire

@@ rtl/mpel_div.sv @@
// ----------------------------------------------------------------------------
// Ratio divider
// Restoring divider, one quotient bit per stage, giving
// floor(num * 2^16 / den) for num <= den.
// ----------------------------------------------------------------------------
`default_nettype none

module mpel_div (
  input  wire logic                           clk,
  input  wire logic [mpel_pkg::DIV_STG:1]     en,
  input  wire logic [mpel_pkg::EST_W-1:0]     est_i,
  input  wire logic [mpel_pkg::EST_W-1:0]     num_i,
  input  mpel_pkg::side_t                     side_i,
  output logic [mpel_pkg::SCALE_W-1:0]        q_o,
  output mpel_pkg::side_t                     side_o
);

  logic [mpel_pkg::REM_W-1:0]   rem_r [1:mpel_pkg::DIV_STG-1];
  logic [mpel_pkg::EST_W-1:0]   den_r [1:mpel_pkg::DIV_STG-1];
  logic [mpel_pkg::SCALE_W-1:0] q_r   [1:mpel_pkg::DIV_STG];
  mpel_pkg::side_t              sd_r  [1:mpel_pkg::DIV_STG];

  logic [mpel_pkg::REM_W-1:0]   rem_in [1:mpel_pkg::DIV_STG];
  logic [mpel_pkg::EST_W-1:0]   den_in [1:mpel_pkg::DIV_STG];
  logic [mpel_pkg::SCALE_W-1:0] q_in   [1:mpel_pkg::DIV_STG];
  mpel_pkg::side_t              sd_in  [1:mpel_pkg::DIV_STG];
  logic [mpel_pkg::DIV_STG:1]   ge;
  logic [mpel_pkg::REM_W-1:0]   rem_sub [1:mpel_pkg::DIV_STG];

  always_comb begin
    rem_in[1] = mpel_pkg::REM_W'(num_i);
    den_in[1] = est_i;
    q_in[1]   = '0;
    sd_in[1]  = side_i;
    for (int j = 2; j <= mpel_pkg::DIV_STG; j++) begin
      rem_in[j] = rem_r[j-1];
      den_in[j] = den_r[j-1];
      q_in[j]   = q_r[j-1];
      sd_in[j]  = sd_r[j-1];
    end
    for (int j = 1; j <= mpel_pkg::DIV_STG; j++) begin
      ge[j]      = rem_in[j] >= mpel_pkg::REM_W'(den_in[j]);
      rem_sub[j] = ge[j] ? rem_in[j] - mpel_pkg::REM_W'(den_in[j]) : rem_in[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 1; j <= mpel_pkg::DIV_STG; j++) begin
      if (en[j]) begin
        q_r[j]  <= {q_in[j][mpel_pkg::SCALE_W-2:0], ge[j]};
        sd_r[j] <= sd_in[j];
      end
    end
    for (int j = 1; j < mpel_pkg::DIV_STG; j++) begin
      if (en[j]) begin
        rem_r[j] <= {rem_sub[j][mpel_pkg::EST_W-1:0], 1'b0};
        den_r[j] <= den_in[j];
      end
    end
  end

  assign q_o    = q_r[mpel_pkg::DIV_STG];
  assign side_o = sd_r[mpel_pkg::DIV_STG];

endmodule

`default_nettype wire

@@ rtl/motor_power_estimate_limit_core.sv @@
// ----------------------------------------------------------------------------
// Motor power estimate and limit
// Chassis power estimate over four motors and the Q1.16 current scale that
// keeps the chassis inside its allowance.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one snapshot per transfer:
//   four current commands, four speeds and the capacitor voltage. The output
//   channel (out_valid/out_ready) returns one result per snapshot, in order.
//   The configuration port writes the power limit (index 0) or the capacitor
//   threshold (index 1); write it only while the block is
//   empty.
//   One snapshot is taken every cycle unless the receiver stalls with the
//   pipeline full. The path is four parallel lanes of six stages, a
//   two-stage merge, a 17-stage restoring divider (one quotient bit a
//   stage) and the output register.
//   When the receiver stalls, each stage holds only if the stage after it is
//   full, so empty stages keep filling and in_ready drops only once all 26
//   stages hold results.
//   Reset empties the pipeline and restores the limit to 100 W and the
//   threshold to 5000 mV. There is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_power_estimate_limit_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [mpel_pkg::CUR_W-1:0]  in_current_0,
  input  wire logic signed [mpel_pkg::CUR_W-1:0]  in_current_1,
  input  wire logic signed [mpel_pkg::CUR_W-1:0]  in_current_2,
  input  wire logic signed [mpel_pkg::CUR_W-1:0]  in_current_3,
  input  wire logic signed [mpel_pkg::SPD_W-1:0]  in_speed_0,
  input  wire logic signed [mpel_pkg::SPD_W-1:0]  in_speed_1,
  input  wire logic signed [mpel_pkg::SPD_W-1:0]  in_speed_2,
  input  wire logic signed [mpel_pkg::SPD_W-1:0]  in_speed_3,
  input  wire logic [mpel_pkg::CAP_W-1:0]         in_cap_voltage_mv,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [mpel_pkg::SCALE_W-1:0]            out_scale_q16,
  output logic [mpel_pkg::MW_W-1:0]               out_power_estimate_mw,
  output logic                                    out_limiting,
  input  wire logic                               cfg_we,
  input  wire logic [mpel_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mpel_pkg::CFG_W-1:0]         cfg_data
);

  logic [mpel_pkg::LIM_W-1:0] limit_r;
  logic [mpel_pkg::THR_W-1:0] thr_r;

  mpel_pkg::stg_vec_t v_r, v_nxt, en;

  logic signed [mpel_pkg::CUR_W-1:0] cur [mpel_pkg::NUM_MOTORS];
  logic signed [mpel_pkg::SPD_W-1:0] spd [mpel_pkg::NUM_MOTORS];
  logic [mpel_pkg::NUM_MOTORS-1:0][mpel_pkg::QM_W-1:0] lane_q;

  logic signed [mpel_pkg::ALLOW_W-1:0] allow;
  logic [mpel_pkg::EST_W-1:0]          est, num;
  mpel_pkg::side_t                     side_m, side_d;
  logic [mpel_pkg::SCALE_W-1:0]        div_q;

  logic [mpel_pkg::SCALE_W-1:0] scale_nxt, scale_r;
  logic [mpel_pkg::MW_W-1:0]    mw_r;
  logic                         lim_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= mpel_pkg::LIMIT_RST;
      thr_r   <= mpel_pkg::THR_RST;
    end else if (cfg_we) begin
      unique case (mpel_pkg::cfg_reg_t'(cfg_index))
        mpel_pkg::REG_POWER_LIMIT:   limit_r <= cfg_data[mpel_pkg::LIM_W-1:0];
        mpel_pkg::REG_CAP_THRESHOLD: thr_r   <= cfg_data[mpel_pkg::THR_W-1:0];
      endcase
    end
  end

  // A stage loads when it, or any stage after it, is empty, or the output is
  // being taken.
  always_comb begin
    for (int k = 1; k <= mpel_pkg::NST; k++) begin
      en[k] = out_ready || (|(~v_r & (mpel_pkg::stg_vec_t'('1) << (k - 1))));
    end
    v_nxt[1] = en[1] ? in_valid : v_r[1];
    for (int k = 2; k <= mpel_pkg::NST; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready = en[1];

  assign cur[0] = in_current_0;
  assign cur[1] = in_current_1;
  assign cur[2] = in_current_2;
  assign cur[3] = in_current_3;
  assign spd[0] = in_speed_0;
  assign spd[1] = in_speed_1;
  assign spd[2] = in_speed_2;
  assign spd[3] = in_speed_3;

  for (genvar m = 0; m < mpel_pkg::NUM_MOTORS; m++) begin : g_lane
    mpel_lane u_lane (
      .clk   (clk),
      .en    (en[mpel_pkg::LANE_STG:1]),
      .cur_i (cur[m]),
      .spd_i (spd[m]),
      .q_o   (lane_q[m])
    );
  end

  mpel_allow u_allow (
    .clk     (clk),
    .en      (en[mpel_pkg::LANE_STG:1]),
    .cap_i   (in_cap_voltage_mv),
    .limit_i (limit_r),
    .thr_i   (thr_r),
    .allow_o (allow)
  );

  mpel_merge u_merge (
    .clk     (clk),
    .en      (en[mpel_pkg::LANE_STG+mpel_pkg::MERGE_STG:mpel_pkg::LANE_STG+1]),
    .q_i     (lane_q),
    .allow_i (allow),
    .est_o   (est),
    .num_o   (num),
    .side_o  (side_m)
  );

  mpel_div u_div (
    .clk    (clk),
    .en     (en[mpel_pkg::DIV_LAST:mpel_pkg::DIV_FIRST]),
    .est_i  (est),
    .num_i  (num),
    .side_i (side_m),
    .q_o    (div_q),
    .side_o (side_d)
  );

  // Output stage: pick full scale, zero, or the biased ratio
  always_comb begin
    priority if (side_d.gt) begin
      scale_nxt = mpel_pkg::ONE_Q16;
    end else if (side_d.zero || (div_q < mpel_pkg::BIAS_Q16)) begin
      scale_nxt = '0;
    end else begin
      scale_nxt = div_q - mpel_pkg::BIAS_Q16;
    end
  end

  always_ff @(posedge clk) begin
    if (en[mpel_pkg::NST]) begin
      scale_r <= scale_nxt;
      mw_r    <= side_d.mw;
      lim_r   <= !side_d.gt;
    end
  end

  assign out_valid             = v_r[mpel_pkg::NST];
  assign out_scale_q16         = scale_r;
  assign out_power_estimate_mw = mw_r;
  assign out_limiting          = lim_r;

  // Limiting is reported exactly when the scale falls short of one.
  a_scale_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_limiting == (out_scale_q16 != mpel_pkg::ONE_Q16))
                  && (out_scale_q16 <= mpel_pkg::ONE_Q16))
    else $error("scale and limiting flag disagree");

  // An empty output register never holds off the input.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[mpel_pkg::NST] |-> in_ready)
    else $error("input stalled with empty output stage");

  // The input is only held off when every stage is full and the output stalls.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r) && !out_ready)
    else $error("input stalled while the pipeline has room");

endmodule

`default_nettype wire
